// ===== src/sur_pkg.sv =====
// Shared types and constants for the surround upmix router.
// No dependencies; every other file in src imports this package.
package sur_pkg;

   localparam int MAX_DELAY_DEF = 2048;
   localparam int SAMPLE_W      = 16;
   localparam int CH_W          = 4;
   localparam int LAYOUT_W      = 2;
   localparam int DLY_W         = 12;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 12;

   localparam logic [CH_W-1:0]  IN_CHANNELS_RST  = 4'd2;
   localparam logic [DLY_W-1:0] DELAY_FRAMES_RST = 12'd480;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum logic [LAYOUT_W-1:0] {
      LAYOUT_4_0 = 2'd0,
      LAYOUT_5_1 = 2'd1,
      LAYOUT_7_1 = 2'd2
   } layout_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IN_CHANNELS  = 2'd0,
      REG_OUT_LAYOUT   = 2'd1,
      REG_DELAY_FRAMES = 2'd2
   } reg_index_type;

   typedef struct packed {
      sample_type in_ch0;
      sample_type in_ch1;
      sample_type in_ch2;
      sample_type in_ch3;
      sample_type in_ch4;
      sample_type in_ch5;
      sample_type in_ch6;
      sample_type in_ch7;
   } frame_in_type;

   typedef struct packed {
      sample_type out_fl;
      sample_type out_fr;
      sample_type out_rl;
      sample_type out_rr;
      sample_type out_fc;
      sample_type out_lfe;
      sample_type out_sl;
      sample_type out_sr;
   } frame_out_type;

   typedef struct packed {
      logic [CH_W-1:0]     in_channels;
      logic [LAYOUT_W-1:0] out_layout;
      logic [DLY_W-1:0]    delay_frames;
   } cfg_type;

   typedef struct packed {
      logic       step;
      logic       clear;
      sample_type left;
      sample_type right;
   } ring_ctl_type;

endpackage

// ===== src/sur_req_if.sv =====
// Request channel: one input frame per handshake.
// Depends on sur_pkg.
interface sur_req_if;
   import sur_pkg::*;
   logic         valid;
   logic         ready;
   frame_in_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/sur_rsp_if.sv =====
// Response channel: one output frame per handshake.
// Depends on sur_pkg.
interface sur_rsp_if;
   import sur_pkg::*;
   logic          valid;
   logic          ready;
   frame_out_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/sur_csr_if.sv =====
// Register write channel: index and data per handshake.
// Depends on sur_pkg.
interface sur_csr_if;
   import sur_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/sur_csr.sv =====
// Configuration registers of the surround upmix router.
// Depends on sur_pkg and sur_csr_if.
module sur_csr (
   input  logic            clock,
   input  logic            reset,
   sur_csr_if.sink         csr_ch,
   output sur_pkg::cfg_type cfg,
   output logic            ring_clear
);
   import sur_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr;

   assign csr_ch.ready = 1'b1;
   assign wr  = csr_ch.valid;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in     = cfg_ff;
      ring_clear = 1'b0;
      if (wr) begin
         unique case (csr_ch.index)
            REG_IN_CHANNELS:  cfg_in.in_channels = csr_ch.data[CH_W-1:0];
            REG_OUT_LAYOUT:   cfg_in.out_layout  = csr_ch.data[LAYOUT_W-1:0];
            REG_DELAY_FRAMES: begin
               cfg_in.delay_frames = csr_ch.data[DLY_W-1:0];
               ring_clear          = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_channels  <= IN_CHANNELS_RST;
         cfg_ff.out_layout   <= LAYOUT_5_1;
         cfg_ff.delay_frames <= DELAY_FRAMES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/sur_map.sv =====
// Channel mapping of one input frame onto the eight output slots.
// Depends on sur_pkg.
module sur_map (
   input  sur_pkg::frame_in_type  din,
   input  sur_pkg::cfg_type       cfg,
   output sur_pkg::frame_out_type dout,
   output logic                   ring_use
);
   import sur_pkg::*;

   layout_type lay;
   sample_type avg;

   assign avg = (din.in_ch0 >>> 1) + (din.in_ch1 >>> 1);

   always_comb begin
      if (cfg.out_layout == LAYOUT_5_1)      lay = LAYOUT_5_1;
      else if (cfg.out_layout == LAYOUT_7_1) lay = LAYOUT_7_1;
      else                                   lay = LAYOUT_4_0;
   end

   always_comb begin
      dout     = '0;
      ring_use = 1'b0;
      case (cfg.in_channels) inside
         4'd1: begin
            dout.out_fl = din.in_ch0;
            dout.out_fr = din.in_ch0;
            dout.out_rl = din.in_ch0;
            dout.out_rr = din.in_ch0;
            if (lay != LAYOUT_4_0) begin
               dout.out_fc  = din.in_ch0;
               dout.out_lfe = din.in_ch0;
            end
            if (lay == LAYOUT_7_1) begin
               dout.out_sl = din.in_ch0;
               dout.out_sr = din.in_ch0;
            end
         end
         4'd2, 4'd3: begin
            dout.out_fl = din.in_ch0;
            dout.out_fr = din.in_ch1;
            // rear pair comes from the ring unless the delay is zero
            if (cfg.delay_frames == '0) begin
               dout.out_rl = din.in_ch0;
               dout.out_rr = din.in_ch1;
            end else begin
               ring_use = 1'b1;
            end
            if (lay != LAYOUT_4_0) begin
               if (cfg.in_channels == 4'd2) begin
                  dout.out_fc  = avg;
                  dout.out_lfe = avg;
                  if (lay == LAYOUT_7_1) begin
                     dout.out_sl = din.in_ch0;
                     dout.out_sr = din.in_ch1;
                  end
               end else begin
                  dout.out_fc  = din.in_ch0;
                  dout.out_lfe = din.in_ch1;
               end
            end
         end
         [4'd4:4'd8]: begin
            dout.out_fl = din.in_ch0;
            dout.out_fr = din.in_ch1;
            dout.out_rl = din.in_ch2;
            dout.out_rr = din.in_ch3;
            if (lay != LAYOUT_4_0) begin
               if (cfg.in_channels == 4'd4) begin
                  dout.out_fc  = din.in_ch0;
                  dout.out_lfe = din.in_ch1;
               end else if (cfg.in_channels == 4'd5) begin
                  dout.out_fc  = din.in_ch4;
                  dout.out_lfe = din.in_ch4;
               end else begin
                  dout.out_fc  = din.in_ch4;
                  dout.out_lfe = din.in_ch5;
                  if (cfg.in_channels == 4'd8 && lay == LAYOUT_7_1) begin
                     dout.out_sl = din.in_ch6;
                     dout.out_sr = din.in_ch7;
                  end
               end
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== src/sur_ring.sv =====
// Rear-channel ring delay: one synchronous memory, ring pointer and fill flag.
// Depends on sur_pkg.
module sur_ring #(
   parameter int MAX_DELAY = sur_pkg::MAX_DELAY_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sur_pkg::ring_ctl_type        ctl,
   input  logic [sur_pkg::DLY_W-1:0]    delay_frames,
   output sur_pkg::sample_type          rd_left,
   output sur_pkg::sample_type          rd_right,
   output logic                         rd_filled
);
   import sur_pkg::*;

   localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
   localparam int CW = (AW + 1 > DLY_W) ? AW + 1 : DLY_W;
   localparam int MW = 2 * SAMPLE_W;

   logic [MW-1:0] mem [MAX_DELAY];
   logic [MW-1:0] rd_ff;
   logic          filled_ff;
   logic [AW-1:0] pos_ff, pos_in;
   logic          wrapped_ff, wrapped_in;
   logic [CW-1:0] dly_ext, eff;
   logic [AW:0]   pos_inc;
   logic          wrap;

   assign dly_ext = CW'(delay_frames);
   assign eff     = (dly_ext > CW'(MAX_DELAY)) ? CW'(MAX_DELAY) : dly_ext;
   assign pos_inc = {1'b0, pos_ff} + 1'b1;
   assign wrap    = CW'(pos_inc) >= eff;

   always_comb begin
      pos_in     = pos_ff;
      wrapped_in = wrapped_ff;
      if (ctl.step) begin
         pos_in = wrap ? '0 : pos_inc[AW-1:0];
         if (wrap) wrapped_in = 1'b1;
      end
   end

   // Entries are visited in order from zero, so until the first wrap the
   // slot at the pointer has not been written since the last clear.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         pos_ff     <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         wrapped_ff <= wrapped_in;
      end
   end

   // Read old contents and write the new pair at the same slot.
   always_ff @(posedge clock) begin
      if (ctl.step) begin
         rd_ff       <= mem[pos_ff];
         filled_ff   <= wrapped_ff;
         mem[pos_ff] <= {ctl.right, ctl.left};
      end
   end

   assign rd_left   = rd_ff[SAMPLE_W-1:0];
   assign rd_right  = rd_ff[MW-1:SAMPLE_W];
   assign rd_filled = filled_ff;

endmodule

// ===== src/surround_upmix_router.sv =====
// Top level of the surround upmix router: registers, mapping, ring delay
// and a two-stage request/response pipeline. Depends on sur_pkg, the three
// channel interfaces, sur_csr, sur_map and sur_ring.
//
//   channel  direction  handshake      payload
//   req_ch   in         valid/ready    in_ch0..in_ch7, signed 16 bit each
//   rsp_ch   out        valid/ready    out_fl..out_sr, signed 16 bit each
//   csr_ch   in         valid/ready    index (2 bit), data (12 bit)
//
// One request per cycle sustained while rsp_ch takes responses; each response passes
// the memory read stage and the output stage before it is offered.
// The rate is set by the ring memory's single read-and-write slot per frame,
// which a request on the delayed rear path uses in its accept cycle.
// Reset is synchronous and active high; it restores the register defaults and
// empties the ring logically through a fill flag, so no clearing pass runs.
// A stalled response holds in the output stage while one more request is taken
// into the memory read stage; after that req_ch.ready drops until rsp drains.
module surround_upmix_router #(
   parameter int MAX_DELAY = sur_pkg::MAX_DELAY_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sur_req_if.sink   req_ch,
   sur_rsp_if.source rsp_ch,
   sur_csr_if.sink   csr_ch
);
   import sur_pkg::*;

   cfg_type       cfg;
   logic          ring_clear;
   frame_out_type map_frame;
   logic          ring_use;
   ring_ctl_type  ring_ctl;
   sample_type    rd_left, rd_right;
   logic          rd_filled;

   // memory read stage
   logic          s1_v_ff, s1_v_in;
   frame_out_type s1_frame_ff;
   logic          s1_ring_ff;
   // output stage
   logic          s2_v_ff, s2_v_in;
   frame_out_type s2_frame_ff, s2_frame_in;

   logic accept, s2_adv;

   sur_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_ch     (csr_ch),
      .cfg        (cfg),
      .ring_clear (ring_clear)
   );

   sur_map u_map (
      .din      (req_ch.data),
      .cfg      (cfg),
      .dout     (map_frame),
      .ring_use (ring_use)
   );

   // Advance the ring only for taken requests that route the rear pair
   // through the delay.
   assign ring_ctl.step  = accept && ring_use;
   assign ring_ctl.clear = ring_clear;
   assign ring_ctl.left  = req_ch.data.in_ch0;
   assign ring_ctl.right = req_ch.data.in_ch1;

   sur_ring #(
      .MAX_DELAY (MAX_DELAY)
   ) u_ring (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ring_ctl),
      .delay_frames (cfg.delay_frames),
      .rd_left      (rd_left),
      .rd_right     (rd_right),
      .rd_filled    (rd_filled)
   );

   assign s2_adv       = s1_v_ff && (!s2_v_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_v_ff || s2_adv;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_v_in = s1_v_ff;
      if (accept)      s1_v_in = 1'b1;
      else if (s2_adv) s1_v_in = 1'b0;

      s2_v_in = s2_v_ff;
      if (s2_adv)            s2_v_in = 1'b1;
      else if (rsp_ch.ready) s2_v_in = 1'b0;

      // Merge the delayed rear pair; an unwritten slot reads as zero.
      s2_frame_in = s1_frame_ff;
      if (s1_ring_ff) begin
         s2_frame_in.out_rl = rd_filled ? rd_left  : '0;
         s2_frame_in.out_rr = rd_filled ? rd_right : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   // Hold payload while stalled.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_frame_ff <= map_frame;
         s1_ring_ff  <= ring_use;
      end
      if (s2_adv) begin
         s2_frame_ff <= s2_frame_in;
      end
   end

   assign rsp_ch.valid = s2_v_ff;
   assign rsp_ch.data  = s2_frame_ff;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for surround_upmix_router: drives frames, register writes
// and response back-pressure, and checks every output frame against a predictor.
// Depends on sur_pkg, the req/rsp/csr channel interfaces and the block itself.
module testbench;
   import sur_pkg::*;

   localparam int TOTAL_FRAMES  = 1550;  // stop offering new frames past this count
   localparam int STALL_LIMIT   = 2000;  // cycles with no handshake before giving up
   localparam int PRESSURE_HOLD = 150;   // one long response stall, in cycles
   localparam int DRAIN_CYCLES  = 8;     // quiet time after the last response

   // Codes outside the defined sets, used to hit the ignore/alias paths.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE    = 2'd3;
   localparam logic [LAYOUT_W-1:0]  LAYOUT_SPARE = 2'd3;

   typedef struct {
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] val;
   } reg_write_type;

   // Predicts the output frame for each accepted request and checks responses
   // against those predictions in order.
   class upmix_scoreboard;
      logic [CH_W-1:0]     chans;
      logic [LAYOUT_W-1:0] layout;
      logic [DLY_W-1:0]    delay;
      int                  ring_pos;
      sample_type          ring_left  [MAX_DELAY_DEF];
      sample_type          ring_right [MAX_DELAY_DEF];
      frame_out_type       frames_due [$];
      int                  errors;
      int                  checked;
      int                  delayed;
      int                  invalid;

      function new();
         chans   = IN_CHANNELS_RST;
         layout  = LAYOUT_5_1;
         delay   = DELAY_FRAMES_RST;
         errors  = 0;
         checked = 0;
         delayed = 0;
         invalid = 0;
         clear_ring();
      endfunction

      function void clear_ring();
         for (int k = 0; k < MAX_DELAY_DEF; k++) begin
            ring_left[k]  = '0;
            ring_right[k] = '0;
         end
         ring_pos = 0;
      endfunction

      function void apply_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_IN_CHANNELS:  chans  = val[CH_W-1:0];
            REG_OUT_LAYOUT:   layout = val[LAYOUT_W-1:0];
            REG_DELAY_FRAMES: begin
               delay = val[DLY_W-1:0];
               clear_ring();
            end
            default: ;
         endcase
      endfunction

      // Map one input frame to its output frame; steps the rear ring when used.
      function frame_out_type map_frame(frame_in_type f);
         sample_type          src [8];
         sample_type          dst [8];
         frame_out_type       res;
         logic [LAYOUT_W-1:0] lay;
         int                  eff;
         int                  span;
         int                  p;
         for (int k = 0; k < 8; k++) begin
            src[k] = f[(7-k)*SAMPLE_W +: SAMPLE_W];
            dst[k] = '0;
         end
         lay = (layout == LAYOUT_SPARE) ? LAYOUT_4_0 : layout;
         case (chans)
            4'd1: begin
               span = (lay == LAYOUT_4_0) ? 4 : (lay == LAYOUT_5_1) ? 6 : 8;
               for (int k = 0; k < span; k++)
                  dst[k] = src[0];
            end
            4'd2, 4'd3: begin
               dst[0] = src[0];
               dst[1] = src[1];
               eff = (delay > MAX_DELAY_DEF) ? MAX_DELAY_DEF : delay;
               if (eff == 0) begin
                  dst[2] = src[0];
                  dst[3] = src[1];
               end else begin
                  // read the oldest pair, then overwrite it with the current one
                  p = (ring_pos >= eff) ? 0 : ring_pos;
                  dst[2] = ring_left[p];
                  dst[3] = ring_right[p];
                  ring_left[p]  = src[0];
                  ring_right[p] = src[1];
                  p++;
                  ring_pos = (p >= eff) ? 0 : p;
                  delayed++;
               end
               if (lay != LAYOUT_4_0) begin
                  if (chans == 4'd2) begin
                     dst[4] = (src[0] >>> 1) + (src[1] >>> 1);
                     dst[5] = dst[4];
                     if (lay == LAYOUT_7_1) begin
                        dst[6] = src[0];
                        dst[7] = src[1];
                     end
                  end else begin
                     dst[4] = src[0];
                     dst[5] = src[1];
                  end
               end
            end
            4'd4, 4'd5, 4'd6, 4'd7, 4'd8: begin
               for (int k = 0; k < 4; k++)
                  dst[k] = src[k];
               if (lay != LAYOUT_4_0) begin
                  if (chans == 4'd4) begin
                     dst[4] = src[0];
                     dst[5] = src[1];
                  end else if (chans == 4'd5) begin
                     dst[4] = src[4];
                     dst[5] = src[4];
                  end else if (chans == 4'd8 && lay == LAYOUT_7_1) begin
                     for (int k = 4; k < 8; k++)
                        dst[k] = src[k];
                  end else begin
                     dst[4] = src[4];
                     dst[5] = src[5];
                  end
               end
            end
            default: invalid++;
         endcase
         for (int k = 0; k < 8; k++)
            res[(7-k)*SAMPLE_W +: SAMPLE_W] = dst[k];
         return res;
      endfunction

      function void note_request(frame_in_type f);
         frames_due.push_back(map_frame(f));
      endfunction

      function void check_response(frame_out_type got);
         frame_out_type want;
         string         names [8] = '{"out_fl", "out_fr", "out_rl", "out_rr",
                                      "out_fc", "out_lfe", "out_sl", "out_sr"};
         if (frames_due.size() == 0) begin
            errors++;
            $display("%0t: response %h with no request outstanding", $time, got);
            return;
         end
         want = frames_due.pop_front();
         checked++;
         for (int k = 0; k < 8; k++) begin
            if (want[(7-k)*SAMPLE_W +: SAMPLE_W] !== got[(7-k)*SAMPLE_W +: SAMPLE_W]) begin
               errors++;
               $display("%0t: %s expected %0d got %0d", $time, names[k],
                        $signed(want[(7-k)*SAMPLE_W +: SAMPLE_W]),
                        $signed(got[(7-k)*SAMPLE_W +: SAMPLE_W]));
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   sur_req_if req_ch ();
   sur_rsp_if rsp_ch ();
   sur_csr_if csr_ch ();

   surround_upmix_router u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   upmix_scoreboard sb;
   reg_write_type   pending_writes [$];
   int              frames_offered = 0;
   int              writes_done    = 0;
   int              stall_cycles   = 0;
   bit              tx_burst       = 0;   // sender offers back to back while set
   bit              pressure_go    = 0;   // asks the response side for its long stall
   bit              pressure_done  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length: drawn from three ranges, the shortest most often, the longest least often.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Sample values lean on the extremes so the sign and rounding paths get hit.
   function automatic frame_in_type random_frame();
      frame_in_type f;
      for (int k = 0; k < 8; k++) begin
         case ($urandom_range(0, 15))
            0:       f[k*SAMPLE_W +: SAMPLE_W] = 16'h8000;
            1:       f[k*SAMPLE_W +: SAMPLE_W] = 16'h7FFF;
            2:       f[k*SAMPLE_W +: SAMPLE_W] = 16'h0000;
            3:       f[k*SAMPLE_W +: SAMPLE_W] = 16'hFFFF;
            4:       f[k*SAMPLE_W +: SAMPLE_W] = 16'h0001;
            default: f[k*SAMPLE_W +: SAMPLE_W] = 16'($urandom);
         endcase
      end
      return f;
   endfunction

   // Offer one request, optionally after an idle gap, and hold it until taken.
   task automatic send_frame(input frame_in_type f);
      int gap;
      gap = (!tx_burst && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= f;
      do @(posedge clock); while (!req_ch.ready);
      frames_offered++;
   endtask

   // Drop the request line and wait until every predicted frame has come back.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (req_ch.valid || sb.frames_due.size() != 0)
         @(posedge clock);
   endtask

   // Apply the queued register writes back to back once the block is idle.
   task automatic flush_reg_writes();
      if (pending_writes.size() == 0)
         return;
      settle();
      foreach (pending_writes[k]) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= pending_writes[k].idx;
         csr_ch.data  <= pending_writes[k].val;
         do @(posedge clock); while (!csr_ch.ready);
      end
      csr_ch.valid <= 1'b0;
      writes_done += pending_writes.size();
      pending_writes.delete();
   endtask

   // Monitor: every handshake is sampled at the edge where it completes.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.data);
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.data);
         if (csr_ch.valid && csr_ch.ready)
            sb.apply_write(csr_ch.index, csr_ch.data);
      end
   end

   // Watchdog: count cycles where no channel moves anything.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // Response side: random stalls, stall-free stretches, and one long hold-off
   // that lets the pipeline fill up and push back on the request side.
   initial begin : rsp_sink
      int hold_left;
      int mode_left;
      bit rx_burst;
      hold_left = 0;
      mode_left = 0;
      rx_burst  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            rx_burst  = ($urandom_range(0, 2) == 0);
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         if (pressure_go && !pressure_done) begin
            pressure_done = 1;
            hold_left     = PRESSURE_HOLD;
         end else if (hold_left == 0 && !rx_burst && $urandom_range(0, 99) < 25) begin
            hold_left = pick_gap();
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      frame_in_type f;
      int           n;
      int           r;
      int           ch;
      int           eff;
      int           cur_delay;
      sb = new();
      cur_delay    = DELAY_FRAMES_RST;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= REG_IN_CHANNELS;
      csr_ch.data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset setting (stereo in, 5.1 out, long delay): full-scale frames and
      // the averaging corner cases; the rear pair must still read zeros.
      send_frame({8{16'h7FFF}});
      send_frame({8{16'h8000}});
      f = random_frame();
      f.in_ch0 = 16'sh8000;
      f.in_ch1 = 16'sh7FFF;
      send_frame(f);
      f.in_ch0 = -16'sd1;
      f.in_ch1 = -16'sd1;
      send_frame(f);
      f.in_ch0 = 16'sd1;
      f.in_ch1 = 16'sd1;
      send_frame(f);

      // Short ring so it wraps; then three-channel mode with the spare layout
      // code, which must keep stepping the same ring.
      pending_writes.push_back('{REG_DELAY_FRAMES, 12'd2});
      pending_writes.push_back('{REG_OUT_LAYOUT, {10'h3FF, LAYOUT_7_1}});
      flush_reg_writes();
      repeat (3) send_frame(random_frame());
      pending_writes.push_back('{REG_IN_CHANNELS, 12'hA03});
      pending_writes.push_back('{REG_OUT_LAYOUT, {10'h000, LAYOUT_SPARE}});
      flush_reg_writes();
      repeat (2) send_frame(random_frame());

      // Zero delay: the rear pair is a straight copy.
      pending_writes.push_back('{REG_DELAY_FRAMES, 12'd0});
      pending_writes.push_back('{REG_IN_CHANNELS, 12'd2});
      pending_writes.push_back('{REG_OUT_LAYOUT, {10'h000, LAYOUT_7_1}});
      flush_reg_writes();
      send_frame(random_frame());

      // Mono fan-out in each layout.
      pending_writes.push_back('{REG_IN_CHANNELS, 12'd1});
      flush_reg_writes();
      send_frame(random_frame());
      pending_writes.push_back('{REG_OUT_LAYOUT, {10'h000, LAYOUT_5_1}});
      flush_reg_writes();
      send_frame(random_frame());
      pending_writes.push_back('{REG_OUT_LAYOUT, {10'h000, LAYOUT_4_0}});
      flush_reg_writes();
      send_frame(random_frame());

      // Multichannel rows.
      pending_writes.push_back('{REG_IN_CHANNELS, 12'd8});
      pending_writes.push_back('{REG_OUT_LAYOUT, {10'h000, LAYOUT_7_1}});
      flush_reg_writes();
      send_frame(random_frame());
      pending_writes.push_back('{REG_IN_CHANNELS, 12'd5});
      pending_writes.push_back('{REG_OUT_LAYOUT, {10'h000, LAYOUT_5_1}});
      flush_reg_writes();
      send_frame(random_frame());
      pending_writes.push_back('{REG_IN_CHANNELS, 12'd6});
      flush_reg_writes();
      send_frame(random_frame());
      pending_writes.push_back('{REG_IN_CHANNELS, 12'd4});
      pending_writes.push_back('{REG_OUT_LAYOUT, {10'h000, LAYOUT_7_1}});
      flush_reg_writes();
      send_frame(random_frame());

      // Channel counts with no mapping row: all-zero output, no state change.
      pending_writes.push_back('{REG_IN_CHANNELS, 12'd9});
      flush_reg_writes();
      send_frame(random_frame());
      pending_writes.push_back('{REG_IN_CHANNELS, 12'd0});
      flush_reg_writes();
      send_frame(random_frame());
      pending_writes.push_back('{REG_IN_CHANNELS, 12'hFFF});
      flush_reg_writes();
      send_frame(random_frame());

      // Write to the spare index (ignored), then delays at and above the store.
      pending_writes.push_back('{REG_SPARE, 12'hFFF});
      pending_writes.push_back('{REG_IN_CHANNELS, 12'd2});
      pending_writes.push_back('{REG_DELAY_FRAMES, 12'hFFF});
      flush_reg_writes();
      send_frame(random_frame());
      pending_writes.push_back('{REG_DELAY_FRAMES, 12'd2048});
      flush_reg_writes();
      send_frame(random_frame());
      cur_delay = 2048;

      // Random phases: each rewrites some registers while idle, then streams
      // frames. Registers left alone carry over, so the ring keeps its
      // contents across channel and layout changes.
      while (frames_offered < TOTAL_FRAMES) begin
         if ($urandom_range(0, 99) < 60) begin
            if ($urandom_range(0, 99) < 88) begin
               ch = $urandom_range(1, 8);
            end else begin
               ch = $urandom_range(8, 15);
               if (ch == 8)
                  ch = 0;
            end
            pending_writes.push_back('{REG_IN_CHANNELS, {8'($urandom), 4'(ch)}});
         end
         if ($urandom_range(0, 99) < 50)
            pending_writes.push_back('{REG_OUT_LAYOUT,
                                       {10'($urandom), 2'($urandom_range(0, 3))}});
         if ($urandom_range(0, 99) < 35) begin
            r = $urandom_range(0, 99);
            if (r < 15)
               cur_delay = 0;
            else if (r < 55)
               cur_delay = $urandom_range(1, 8);
            else if (r < 80)
               cur_delay = $urandom_range(9, 64);
            else if (r < 90)
               cur_delay = $urandom_range(2040, 2048);
            else
               cur_delay = $urandom_range(2049, 4095);
            pending_writes.push_back('{REG_DELAY_FRAMES, 12'(cur_delay)});
         end
         eff = (cur_delay > MAX_DELAY_DEF) ? MAX_DELAY_DEF : cur_delay;
         // short rings may get enough frames to wrap a couple of times
         n = (eff <= 64) ? $urandom_range(5, 2 * eff + 20) : $urandom_range(4, 20);
         flush_reg_writes();
         tx_burst = ($urandom_range(0, 3) == 0);
         if (!pressure_go && frames_offered >= 700) begin
            // keep offering back to back while the response side holds off
            tx_burst    = 1;
            n           = 40;
            pressure_go = 1;
         end
         repeat (n) send_frame(random_frame());
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d frames, %0d through the rear delay line and %0d with",
               sb.checked, sb.delayed, sb.invalid);
      $display("an unmapped channel count, over %0d register writes.", writes_done);
      if (sb.errors == 0 && sb.frames_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
